[hw/rtl/sgm_pkg.sv]
// Shared types and constants for the stencil gather MAC block.
package sgm_pkg;

  localparam int unsigned MAX_TAPS_DEF    = 32;
  localparam int unsigned FIELD_DEPTH_DEF = 4096;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned LOC_W    = 13;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned CFG_W    = 6;

  localparam logic [CFG_W-1:0] TAP_COUNT_RST = CFG_W'(1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_WR_WEIGHT = 2'd0,
    ACT_WR_FIELD  = 2'd1,
    ACT_GATHER    = 2'd2,
    ACT_NONE      = 2'd3
  } action_e;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Signed add that clamps to the 64-bit range.
  function automatic sum_t sat_add(sum_t a, sum_t b);
    sum_t s;
    s = a + b;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (s[SUM_W-1] != a[SUM_W-1])) begin
      s = a[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage

[hw/rtl/sgm_ram.sv]
// Generic single-port synchronous RAM with registered read data.
module sgm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/stencil_gather_mac_top.sv]
// Top level of the stencil gather MAC: weight and field RAMs, multiply and accumulate.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: action_i selects a
//   weight write, a complex field write or one gather tap at 1-based location_i.
//   Output channel (out_valid_o / out_stall_i) carries one point's Q32.32 sums and
//   bad_index_o after tap_count taps (0 acts as 1, capped at MAX_TAPS). Config
//   channel (cfg_valid_i / cfg_ready_o) writes tap_count and is always ready; the user
//   must see that it is written only while idle, which the block does not enforce.
// Timing:
//   A weight or field write completes at accept. A tap runs as RAM read at accept,
//   registered 32x32 multiply, then saturating accumulate; items are processed one
//   at a time, so the input stalls during the multiply and accumulate states. A
//   result is registered when the last tap of a point commits in accumulate.
// Reset:
//   Accumulators, tap counter and error flag clear, tap_count returns to 1.
//   RAM contents are undefined until written; no clearing pass runs.
// Backpressure:
//   The result register holds while out_stall_i is high; new items are still
//   taken, and only a tap that would close another point waits in the
//   accumulate state until the result register frees.
module stencil_gather_mac_top #(
  parameter int unsigned MAX_TAPS    = sgm_pkg::MAX_TAPS_DEF,
  parameter int unsigned FIELD_DEPTH = sgm_pkg::FIELD_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sgm_pkg::ACTION_W-1:0]  action_i,
  input  logic [sgm_pkg::LOC_W-1:0]     location_i,
  input  logic signed [sgm_pkg::VAL_W-1:0] value_re_i,
  input  logic signed [sgm_pkg::VAL_W-1:0] value_im_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [sgm_pkg::SUM_W-1:0] sum_re_o,
  output logic signed [sgm_pkg::SUM_W-1:0] sum_im_o,
  output logic                          bad_index_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sgm_pkg::CFG_W-1:0]     cfg_data_i
);

  import sgm_pkg::*;

  localparam int unsigned AW   = (FIELD_DEPTH > 1) ? $clog2(FIELD_DEPTH) : 1;
  localparam int unsigned TW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CW   = (AW + 1 > LOC_W) ? AW + 1 : LOC_W;
  localparam int unsigned CNTW = $clog2(MAX_TAPS + 1);
  localparam int unsigned NW   = (CNTW > CFG_W) ? CNTW : CFG_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_ACC  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  tap_count_q;
  logic [TW-1:0]     cnt_q, cnt_d;
  sum_t              acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic              err_q, err_d;
  logic              bad_mul_q, bad_acc_q;
  sum_t              prod_re_q, prod_im_q;
  logic              out_valid_q, out_valid_d;
  sum_t              out_re_q, out_im_q;
  logic              out_bad_q;

  logic              accept;
  action_e           act;
  logic [CW-1:0]     loc_c;
  logic              tap_bad;
  logic              field_wr_ok, weight_wr_ok;
  logic              fld_en, fld_we;
  logic [AW-1:0]     fld_addr;
  logic [2*VAL_W-1:0] fld_rdata;
  logic              wgt_en, wgt_we;
  logic [TW-1:0]     wgt_addr;
  logic [VAL_W-1:0]  wgt_rdata;
  val_t              w_s, f_re_s, f_im_s;
  sum_t              prod_re_d, prod_im_d;
  sum_t              add_re, add_im;
  logic [NW-1:0]     need;
  logic              finish, out_busy, commit;

  assign act         = action_e'(action_i);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign loc_c        = CW'(location_i);
  assign tap_bad      = (loc_c == '0) || (loc_c > CW'(FIELD_DEPTH));
  assign field_wr_ok  = loc_c < CW'(FIELD_DEPTH);
  assign weight_wr_ok = location_i < LOC_W'(MAX_TAPS);

  // Field RAM: real part low, imaginary high; taps read address index-1.
  assign fld_we   = (act == ACT_WR_FIELD);
  assign fld_en   = accept && ((fld_we && field_wr_ok) || (act == ACT_GATHER && !tap_bad));
  assign fld_addr = fld_we ? AW'(loc_c) : AW'(loc_c - CW'(1));

  assign wgt_we   = (act == ACT_WR_WEIGHT);
  assign wgt_en   = accept && ((wgt_we && weight_wr_ok) || act == ACT_GATHER);
  assign wgt_addr = wgt_we ? TW'(location_i) : cnt_q;

  sgm_ram #(
    .WIDTH (2*VAL_W),
    .DEPTH (FIELD_DEPTH),
    .AW    (AW)
  ) u_field_ram (
    .clk_i   (clk_i),
    .en_i    (fld_en),
    .we_i    (fld_we),
    .addr_i  (fld_addr),
    .wdata_i ({value_im_i, value_re_i}),
    .rdata_o (fld_rdata)
  );

  sgm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_TAPS),
    .AW    (TW)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .en_i    (wgt_en),
    .we_i    (wgt_we),
    .addr_i  (wgt_addr),
    .wdata_i (value_re_i),
    .rdata_o (wgt_rdata)
  );

  assign w_s       = val_t'(wgt_rdata);
  assign f_re_s    = val_t'(fld_rdata[VAL_W-1:0]);
  assign f_im_s    = val_t'(fld_rdata[2*VAL_W-1:VAL_W]);
  assign prod_re_d = sum_t'(w_s) * sum_t'(f_re_s);
  assign prod_im_d = sum_t'(w_s) * sum_t'(f_im_s);

  assign add_re = sat_add(acc_re_q, prod_re_q);
  assign add_im = sat_add(acc_im_q, prod_im_q);

  always_comb begin
    if (tap_count_q == '0) begin
      need = NW'(1);
    end else if (NW'(tap_count_q) > NW'(MAX_TAPS)) begin
      need = NW'(MAX_TAPS);
    end else begin
      need = NW'(tap_count_q);
    end
  end

  assign finish   = (NW'(cnt_q) + NW'(1)) >= need;
  assign out_busy = out_valid_q && out_stall_i;
  assign commit   = (state_q == ST_ACC) && finish && !out_busy;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_re_d    = acc_re_q;
    acc_im_d    = acc_im_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && act == ACT_GATHER) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (!finish) begin
          state_d = ST_IDLE;
          cnt_d   = cnt_q + TW'(1);
          if (bad_acc_q) begin
            err_d = 1'b1;
          end else begin
            acc_re_d = add_re;
            acc_im_d = add_im;
          end
        end else if (!out_busy) begin
          state_d     = ST_IDLE;
          cnt_d       = '0;
          acc_re_d    = '0;
          acc_im_d    = '0;
          err_d       = 1'b0;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tap_count_q <= TAP_COUNT_RST;
      cnt_q       <= '0;
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      acc_re_q    <= acc_re_d;
      acc_im_q    <= acc_im_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tap_count_q <= cfg_data_i;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bad_mul_q <= tap_bad;
    end
    if (state_q == ST_MUL) begin
      prod_re_q <= prod_re_d;
      prod_im_q <= prod_im_d;
      bad_acc_q <= bad_mul_q;
    end
    if (commit) begin
      out_re_q  <= bad_acc_q ? acc_re_q : add_re;
      out_im_q  <= bad_acc_q ? acc_im_q : add_im;
      out_bad_q <= err_q || bad_acc_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_re_o    = out_re_q;
  assign sum_im_o    = out_im_q;
  assign bad_index_o = out_bad_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW'(cnt_q) < NW'(MAX_TAPS))
    else $error("tap counter beyond slot range");

  a_gather_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && act == ACT_GATHER) |=> (state_q == ST_MUL))
    else $error("gather tap did not enter multiply");

  a_write_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && act != ACT_GATHER) |=> (state_q == ST_IDLE))
    else $error("write item left idle");

  a_result_from_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_ACC))
    else $error("result raised outside accumulate");

  a_commit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (cnt_q == '0 && acc_re_q == '0 && acc_im_q == '0 && !err_q))
    else $error("point state not cleared after result");

endmodule
